[rtl/core/trct_pkg.sv]
`default_nettype none

package trct_pkg;

    // Default number of tracked rays.
    localparam int MAX_RAYS_DEF = 4096;

    // Ray index as carried in a request, and a width that can hold any ray count.
    localparam int RAY_IDX_W = 12;
    localparam int RAY_EXT_W = 17;

    localparam int COORD_W = 16;
    localparam int CNT_W   = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int TRUNC_W = 15;
    localparam logic [TRUNC_W-1:0] TRUNC_RESET = 15'd600;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ASSOC_MODE  = 1'd0,
        CFG_TRUNC_LIMIT = 1'd1
    } t_cfg_idx;

    typedef enum logic {
        MODE_ASSOC = 1'b0,
        MODE_COUNT = 1'b1
    } t_mode;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        RAY_INIT = 2'd0,
        RAY_HIT  = 2'd1,
        RAY_ZERO = 2'd2,
        RAY_DONE = 2'd3
    } t_ray_status;

    typedef enum logic [1:0] {
        KIND_STATUS    = 2'd0,
        KIND_INTERSECT = 2'd1,
        KIND_ZERO      = 2'd2,
        KIND_NEGATIVE  = 2'd3
    } t_assoc_kind;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_cell;

    typedef struct packed {
        logic [1:0] status;
        logic       pend;
    } t_ray_entry;

    localparam int CELL_W  = $bits(t_cell);
    localparam int ENTRY_W = $bits(t_ray_entry);

    typedef struct packed {
        logic                      req_type;
        logic [RAY_IDX_W-1:0]      ray_index;
        logic                      out_of_bounds;
        logic signed [COORD_W-1:0] tsdf_value;
        logic [15:0]               tsdf_weight;
        logic signed [COORD_W-1:0] in_cell_x;
        logic signed [COORD_W-1:0] in_cell_y;
        logic signed [COORD_W-1:0] in_cell_z;
    } t_in_req;

    typedef struct packed {
        logic [1:0]                assoc_kind;
        logic signed [COORD_W-1:0] assoc_x;
        logic signed [COORD_W-1:0] assoc_y;
        logic signed [COORD_W-1:0] assoc_z;
        logic [1:0]                ray_status;
        logic [CNT_W-1:0]          finished_count;
        logic [CNT_W-1:0]          good_count;
        logic [CNT_W-1:0]          not_good_count;
        logic                      last;
    } t_out_res;

    // Saturating counter increment.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/core/trct_ram.sv]
`default_nettype none

module trct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read.
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/tsdf_ray_crossing_tracker_core.sv]
`default_nettype none

// Ray crossing tracker for TSDF ray casting. Each request is either a ray
// sample (ray index, out-of-bounds flag, TSDF value, weight and cell) or a
// clear for a new scan. For every ray the block keeps a status (init, hit,
// zero crossed, finished) and one pending near-surface cell, and for every
// request it delivers one or two results, the final one marked by last. In
// associate mode the results carry the associated cells; in count mode the
// block counts rays that finished after a full crossing (good) and rays that
// left the box (not good). The accept cycle of a sample reads the ray's entry from
// the status memory; the lookup state, once the output slot is free, modifies and
// writes it back and loads the result. The status memory has separate read and
// write ports. No request is taken while one is in lookup or its trailing result
// waits. After reset and after every clear request, a clearing pass over all
// MAX_RAYS entries returns the status memory to init while requests stall;
// configuration writes are taken at all times. The user must write configuration
// only while no request is in flight; the block itself does not enforce this.

module tsdf_ray_crossing_tracker_core #(
    parameter int MAX_RAYS = trct_pkg::MAX_RAYS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire trct_pkg::t_in_req               i_in,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output trct_pkg::t_out_res                   o_out,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [trct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [trct_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_RAYS > 1) ? $clog2(MAX_RAYS) : 1;
    localparam int EW = trct_pkg::RAY_EXT_W;
    localparam int CW = trct_pkg::CNT_W;
    localparam int COORD_W_EXT = trct_pkg::COORD_W + 1;

    // Configuration registers.
    logic                               r_assoc_mode;
    logic [trct_pkg::TRUNC_W-1:0]       r_trunc;

    trct_pkg::t_state                   r_state, n_state;
    logic [AW-1:0]                      r_sweep_addr;
    trct_pkg::t_in_req                  r_req;

    logic [CW-1:0]                      r_fin, r_good, r_ng;
    logic [CW-1:0]                      n_fin, n_good, n_ng;

    // Output slot plus a second slot for the trailing result of a request.
    logic                               r_out_valid, r_pend_valid;
    trct_pkg::t_out_res                 r_out, r_pend;

    // Memory ports.
    logic                               st_we, cell_we;
    logic [AW-1:0]                      st_waddr;
    trct_pkg::t_ray_entry               st_wdata;
    logic [trct_pkg::ENTRY_W-1:0]       st_rdata;
    logic [trct_pkg::CELL_W-1:0]        cell_rdata;
    trct_pkg::t_ray_entry               rd_entry;
    trct_pkg::t_cell                    rd_cell, req_cell;

    logic                               in_accept, out_take, out_free, proceed;
    logic                               sweep_last, in_range, is_clear;
    logic [EW-1:0]                      in_idx_ext, req_idx_ext;
    logic [AW-1:0]                      req_addr;
    logic                               neg, near;
    logic signed [COORD_W_EXT-1:0]      val_ext, trunc_ext;

    trct_pkg::t_ray_status              n_status;
    logic                               n_pend_bit;
    logic [1:0]                         kind1, kind2;
    trct_pkg::t_cell                    cell1, cell2;
    logic                               two;
    trct_pkg::t_out_res                 res1, res2;

    // ------------------------------------------------------------------
    // Handshakes. Requests enter only when the trailing slot is empty, so the
    // lookup cycle never has to park two results behind a busy output.
    // ------------------------------------------------------------------
    assign o_in_stall  = !((r_state == trct_pkg::ST_IDLE) && !r_pend_valid);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_take    = r_out_valid && !i_out_stall;
    assign out_free    = !r_out_valid || out_take;
    assign proceed     = (r_state == trct_pkg::ST_LOOK) && out_free;
    assign o_cfg_ready = 1'b1;

    assign in_idx_ext  = EW'(i_in.ray_index);
    assign req_idx_ext = EW'(r_req.ray_index);
    assign req_addr    = req_idx_ext[AW-1:0];
    assign in_range    = req_idx_ext < EW'(MAX_RAYS);
    assign is_clear    = (r_req.req_type == trct_pkg::REQ_CLEAR);
    assign sweep_last  = (r_sweep_addr == AW'(MAX_RAYS - 1));

    assign rd_entry = trct_pkg::t_ray_entry'(st_rdata);
    assign rd_cell  = trct_pkg::t_cell'(cell_rdata);
    assign req_cell = '{x: r_req.in_cell_x, y: r_req.in_cell_y, z: r_req.in_cell_z};

    // Sample classification: weighted negative and near surface.
    assign val_ext   = {r_req.tsdf_value[trct_pkg::COORD_W-1], r_req.tsdf_value};
    assign trunc_ext = $signed({2'b00, r_trunc});
    assign neg  = r_req.tsdf_value[trct_pkg::COORD_W-1] && (r_req.tsdf_weight != '0);
    assign near = (val_ext < trunc_ext) && (r_req.tsdf_weight != '0);

    // ------------------------------------------------------------------
    // Status memory holds the ray status and the pending-valid bit; the cell
    // memory holds the pending cell and is never cleared. Both are read in
    // the accept cycle. The write-back lands at the edge that leaves the
    // lookup state, before any later read can be issued, so no forwarding
    // is needed.
    // ------------------------------------------------------------------
    trct_ram #(
        .WIDTH (trct_pkg::ENTRY_W),
        .DEPTH (MAX_RAYS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (in_accept),
        .i_raddr (in_idx_ext[AW-1:0]),
        .o_rdata (st_rdata)
    );

    trct_ram #(
        .WIDTH (trct_pkg::CELL_W),
        .DEPTH (MAX_RAYS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (req_addr),
        .i_wdata (req_cell),
        .i_re    (in_accept),
        .i_raddr (in_idx_ext[AW-1:0]),
        .o_rdata (cell_rdata)
    );

    // ------------------------------------------------------------------
    // Ray step: next status, pending bit, counters and the results.
    // ------------------------------------------------------------------
    always_comb begin
        n_status   = trct_pkg::t_ray_status'(rd_entry.status);
        n_pend_bit = rd_entry.pend;
        n_fin      = r_fin;
        n_good     = r_good;
        n_ng       = r_ng;
        kind1      = trct_pkg::KIND_STATUS;
        kind2      = trct_pkg::KIND_STATUS;
        cell1      = '0;
        cell2      = '0;
        two        = 1'b0;
        cell_we    = 1'b0;

        if (is_clear) begin
            n_status = trct_pkg::RAY_INIT;
            n_fin    = '0;
            n_good   = '0;
            n_ng     = '0;
        end else if (!in_range) begin
            n_status = trct_pkg::RAY_INIT;
        end else begin
            case (rd_entry.status)
                trct_pkg::RAY_DONE: begin
                end
                default: begin
                    if (r_req.out_of_bounds) begin
                        // Leaving the box finishes the ray as not good.
                        n_status = trct_pkg::RAY_DONE;
                        n_fin    = trct_pkg::sat_inc(r_fin);
                        if (r_assoc_mode == trct_pkg::MODE_COUNT) begin
                            n_ng = trct_pkg::sat_inc(r_ng);
                        end
                    end else begin
                        case (rd_entry.status)
                            trct_pkg::RAY_INIT: begin
                                if (!neg && near) begin
                                    n_status   = trct_pkg::RAY_HIT;
                                    n_pend_bit = 1'b1;
                                    cell_we    = proceed;
                                end
                            end
                            trct_pkg::RAY_HIT: begin
                                if (neg) begin
                                    // Zero crossing flushes the pending cell first.
                                    n_status   = trct_pkg::RAY_ZERO;
                                    n_pend_bit = 1'b0;
                                    if (r_assoc_mode == trct_pkg::MODE_ASSOC) begin
                                        if (rd_entry.pend) begin
                                            kind1 = trct_pkg::KIND_INTERSECT;
                                            cell1 = rd_cell;
                                            kind2 = trct_pkg::KIND_ZERO;
                                            cell2 = req_cell;
                                            two   = 1'b1;
                                        end else begin
                                            kind1 = trct_pkg::KIND_ZERO;
                                            cell1 = req_cell;
                                        end
                                    end
                                end else if (!near) begin
                                    n_status   = trct_pkg::RAY_INIT;
                                    n_pend_bit = 1'b0;
                                end else if (r_assoc_mode == trct_pkg::MODE_ASSOC) begin
                                    kind1 = trct_pkg::KIND_INTERSECT;
                                    cell1 = req_cell;
                                end
                            end
                            default: begin
                                // Zero crossed: leaving the negative side completes it.
                                if (!neg) begin
                                    n_status = trct_pkg::RAY_DONE;
                                    n_fin    = trct_pkg::sat_inc(r_fin);
                                    if (r_assoc_mode == trct_pkg::MODE_COUNT) begin
                                        n_good = trct_pkg::sat_inc(r_good);
                                    end
                                end else if (r_assoc_mode == trct_pkg::MODE_ASSOC) begin
                                    kind1 = trct_pkg::KIND_NEGATIVE;
                                    cell1 = req_cell;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end

        res1 = '{assoc_kind: kind1, assoc_x: cell1.x, assoc_y: cell1.y, assoc_z: cell1.z,
                 ray_status: n_status, finished_count: n_fin, good_count: n_good,
                 not_good_count: n_ng, last: !two};
        res2 = '{assoc_kind: kind2, assoc_x: cell2.x, assoc_y: cell2.y, assoc_z: cell2.z,
                 ray_status: n_status, finished_count: n_fin, good_count: n_good,
                 not_good_count: n_ng, last: 1'b1};
    end

    // Status memory write: the clearing pass, or the write-back of a sample.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = req_addr;
        st_wdata = '{status: n_status, pend: n_pend_bit};
        if (r_state == trct_pkg::ST_SWEEP) begin
            st_we    = 1'b1;
            st_waddr = r_sweep_addr;
            st_wdata = '{status: trct_pkg::RAY_INIT, pend: 1'b0};
        end else if (proceed && !is_clear && in_range) begin
            st_we = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            trct_pkg::ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = trct_pkg::ST_IDLE;
                end
            end
            trct_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = trct_pkg::ST_LOOK;
                end
            end
            trct_pkg::ST_LOOK: begin
                if (proceed) begin
                    n_state = is_clear ? trct_pkg::ST_SWEEP : trct_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = trct_pkg::ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= trct_pkg::ST_SWEEP;
            r_sweep_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == trct_pkg::ST_SWEEP) begin
                r_sweep_addr <= sweep_last ? '0 : r_sweep_addr + AW'(1);
            end
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in;
        end
    end

    // Counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin  <= '0;
            r_good <= '0;
            r_ng   <= '0;
        end else if (proceed) begin
            r_fin  <= n_fin;
            r_good <= n_good;
            r_ng   <= n_ng;
        end
    end

    // Result slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (proceed) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= two;
        end else if (out_take) begin
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed) begin
            r_out  <= res1;
            r_pend <= res2;
        end else if (out_take) begin
            r_out <= r_pend;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assoc_mode <= trct_pkg::MODE_ASSOC;
            r_trunc      <= trct_pkg::TRUNC_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                trct_pkg::CFG_ASSOC_MODE: begin
                    r_assoc_mode <= i_cfg_data[0];
                end
                trct_pkg::CFG_TRUNC_LIMIT: begin
                    r_trunc <= i_cfg_data[trct_pkg::TRUNC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_look_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == trct_pkg::ST_LOOK) |-> !r_pend_valid)
        else $error("trailing result slot busy during lookup");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == trct_pkg::ST_LOOK))
        else $error("accepted request did not enter lookup");

    a_pend_behind_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_out_valid && !r_out.last))
        else $error("trailing result without a leading non-final result");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_good <= r_fin) && (r_ng <= r_fin))
        else $error("good or not-good count exceeds finished count");

endmodule

`default_nettype wire
